/* design/vqdm_pkg.sv */
// Shared types and constants for the virtqueue descriptor manager.
// No dependencies; every other design file refers to this package by scope.
`timescale 1ns / 1ps

package vqdm_pkg;

  // Field widths
  localparam int IDX_W  = 8;
  localparam int SIZE_W = 9;
  localparam int CNT_W  = 16;
  localparam int ACT_W  = 2;
  localparam int STS_W  = 2;

  // Default queue depth limit
  localparam int MAX_QUEUE_DEF = 256;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LINK     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POST     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd3;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_FREE = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;
  localparam logic [STS_W-1:0] STS_CHAIN   = 2'd3;

  // Descriptor flag bits as kept in the link table
  localparam logic [1:0] DESC_F_NEXT  = 2'd1;
  localparam logic [1:0] DESC_F_WRITE = 2'd2;

  // Free stack access: clear (refill), one write and one read address
  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } stk_req_t;

  // Link table access: one write and one read address
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [1:0]       flags;
    logic [IDX_W-1:0] next;
    logic [IDX_W-1:0] raddr;
  } lnk_req_t;

  // Link table read word
  typedef struct packed {
    logic [1:0]       flags;
    logic [IDX_W-1:0] next;
  } lnk_t;

  // One result transaction
  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  index_out;
    logic [SIZE_W-1:0] free_count;
    logic [CNT_W-1:0]  avail_head;
    logic [CNT_W-1:0]  progress_head;
    logic [SIZE_W-1:0] freed_count;
  } rsp_t;

endpackage

/* design/vqdm_if.sv */
// Channel interfaces: configuration write, request and response.
// Depends on vqdm_pkg for field widths.
`timescale 1ns / 1ps

interface vqdm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [vqdm_pkg::SIZE_W-1:0] queue_size;

  modport source (output valid, output queue_size, input ready);
  modport sink   (input valid, input queue_size, output ready);
endinterface

interface vqdm_req_if;
  logic                       valid;
  logic                       ready;
  logic [vqdm_pkg::ACT_W-1:0] action;
  logic [vqdm_pkg::IDX_W-1:0] desc_id;
  logic                       write_flag;
  logic                       has_next;
  logic [vqdm_pkg::IDX_W-1:0] next_index;

  modport source (output valid, output action, output desc_id, output write_flag,
                  output has_next, output next_index, input ready);
  modport sink   (input valid, input action, input desc_id, input write_flag,
                  input has_next, input next_index, output ready);
endinterface

interface vqdm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [vqdm_pkg::STS_W-1:0]  status;
  logic [vqdm_pkg::IDX_W-1:0]  index_out;
  logic [vqdm_pkg::SIZE_W-1:0] free_count;
  logic [vqdm_pkg::CNT_W-1:0]  avail_head;
  logic [vqdm_pkg::CNT_W-1:0]  progress_head;
  logic [vqdm_pkg::SIZE_W-1:0] freed_count;

  modport source (output valid, output status, output index_out, output free_count,
                  output avail_head, output progress_head, output freed_count,
                  input ready);
  modport sink   (input valid, input status, input index_out, input free_count,
                  input avail_head, input progress_head, input freed_count,
                  output ready);
endinterface

/* design/vqdm_free_stack.sv */
// Free descriptor stack: synchronous memory with per-entry valid bits.
// An entry never written since the last refill reads as its own position.
// Depends on vqdm_pkg.
`timescale 1ns / 1ps

module vqdm_free_stack #(
  parameter int DEPTH = vqdm_pkg::MAX_QUEUE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vqdm_pkg::stk_req_t         req,
  output logic [vqdm_pkg::IDX_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    mem_q;
  logic [AW-1:0]    addr_q;
  logic             valid_q;

  // Store pushed indices
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata[AW-1:0];
    end
  end

  // Drop all written entries on reset or refill
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr[AW-1:0]] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    mem_q   <= mem[req.raddr[AW-1:0]];
    valid_q <= valid[req.raddr[AW-1:0]];
    addr_q  <= req.raddr[AW-1:0];
  end

  assign rdata = valid_q ? vqdm_pkg::IDX_W'(mem_q) : vqdm_pkg::IDX_W'(addr_q);

endmodule

/* design/vqdm_link_mem.sv */
// Descriptor link table: flags and next index per descriptor.
// Synchronous memory, one write and one registered read. Depends on vqdm_pkg.
`timescale 1ns / 1ps

module vqdm_link_mem #(
  parameter int DEPTH = vqdm_pkg::MAX_QUEUE_DEF
) (
  input  logic               clk,
  input  vqdm_pkg::lnk_req_t req,
  output vqdm_pkg::lnk_t     rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [AW+1:0] mem [DEPTH];
  logic [AW+1:0] rd_q;

  // Write flags and truncated next index
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= {req.flags, req.next[AW-1:0]};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_q <= mem[req.raddr[AW-1:0]];
  end

  assign rdata.flags = rd_q[AW+1:AW];
  assign rdata.next  = vqdm_pkg::IDX_W'(rd_q[AW-1:0]);

endmodule

/* design/virtqueue_descriptor_manager.sv */
// Top level of the split virtqueue descriptor manager: sequencer, avail ring,
// counters and result register. Uses vqdm_pkg, vqdm_if, vqdm_free_stack,
// vqdm_link_mem.
//
//   Channel  Modport  Transaction carries
//   -------  -------  ------------------------------------------------------
//   cfg      sink     queue_size (refills free stack, clears head counters)
//   req      sink     action, desc_id, write_flag, has_next, next_index
//   rsp      source   status, index_out, free_count, avail_head,
//                     progress_head, freed_count
//
// Allocate, link and post issue the memory read when the request is accepted
// and use the read data in S_EXEC. Complete walks a chain through S_EXEC and
// S_WALK; the registered link table read sets one descriptor per cycle in the walk.
// Reset (synchronous) restores queue size to the depth limit with all
// descriptors free; no clearing pass is needed. A stalled response is held in
// its register; the block takes the next request meanwhile and stalls only
// when a second result is ready before the first is taken.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager #(
  parameter int MAX_QUEUE = vqdm_pkg::MAX_QUEUE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vqdm_cfg_if.sink   cfg,
  vqdm_req_if.sink   req,
  vqdm_rsp_if.source rsp
);

  localparam int LIM = (MAX_QUEUE < 256) ? MAX_QUEUE : 256;
  localparam int AW  = $clog2(LIM);
  localparam logic [vqdm_pkg::SIZE_W-1:0] LIM_SZ = vqdm_pkg::SIZE_W'(LIM);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Latched request
  logic [vqdm_pkg::ACT_W-1:0] act;
  logic [vqdm_pkg::IDX_W-1:0] desc;
  logic                       wflag;
  logic                       hnext;
  logic [vqdm_pkg::IDX_W-1:0] nidx;

  // Bookkeeping registers
  logic [vqdm_pkg::SIZE_W-1:0] eff_size;
  logic [vqdm_pkg::SIZE_W-1:0] free_top;
  logic [vqdm_pkg::SIZE_W-1:0] free_top_next;
  logic [vqdm_pkg::CNT_W-1:0]  avail_head;
  logic [vqdm_pkg::CNT_W-1:0]  avail_head_next;
  logic [AW-1:0]               slot;
  logic [AW-1:0]               slot_next;
  logic [vqdm_pkg::CNT_W-1:0]  progress;
  logic [vqdm_pkg::CNT_W-1:0]  progress_next;
  logic [vqdm_pkg::SIZE_W-1:0] freed;
  logic [vqdm_pkg::SIZE_W-1:0] freed_next;
  logic [vqdm_pkg::IDX_W-1:0]  cur;
  logic [vqdm_pkg::IDX_W-1:0]  cur_next;

  logic [AW-1:0] avail_ring [LIM];
  logic          avail_we;

  vqdm_pkg::stk_req_t          stk;
  vqdm_pkg::lnk_req_t          lnk;
  logic [vqdm_pkg::IDX_W-1:0]  stk_rdata;
  vqdm_pkg::lnk_t              lnk_rdata;

  vqdm_pkg::rsp_t res_c;
  vqdm_pkg::rsp_t res_hold;
  vqdm_pkg::rsp_t rsp_q;
  logic           rsp_valid;
  logic           fin;
  logic           out_free;
  logic           req_acc;
  logic           cfg_acc;

  logic [vqdm_pkg::SIZE_W-1:0] cfg_eff;
  logic [vqdm_pkg::SIZE_W-1:0] ft_dec;
  logic [vqdm_pkg::SIZE_W-1:0] ft_inc;
  logic                        desc_oor;
  logic                        nidx_oor;
  logic                        lk_oor;
  logic                        walk;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_acc   = req.valid && req.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  // Clamp the written size to 1..LIM
  always_comb begin
    if (cfg.queue_size == '0) begin
      cfg_eff = vqdm_pkg::SIZE_W'(1);
    end else if (cfg.queue_size > LIM_SZ) begin
      cfg_eff = LIM_SZ;
    end else begin
      cfg_eff = cfg.queue_size;
    end
  end

  assign ft_dec   = free_top - vqdm_pkg::SIZE_W'(1);
  assign ft_inc   = free_top + vqdm_pkg::SIZE_W'(1);
  assign desc_oor = {1'b0, desc} >= eff_size;
  assign nidx_oor = hnext && ({1'b0, nidx} >= eff_size);
  assign lk_oor   = {1'b0, lnk_rdata.next} >= eff_size;

  // Chain walk runs in the execute cycle for an in-range complete with descriptors in use, then in S_WALK
  assign walk = (state == S_WALK) ||
                ((state == S_EXEC) && (act == vqdm_pkg::ACT_COMPLETE) && !desc_oor &&
                 (free_top != eff_size));

  // Sequencer datapath
  always_comb begin
    free_top_next   = free_top;
    avail_head_next = avail_head;
    slot_next       = slot;
    progress_next   = progress;
    freed_next      = freed;
    cur_next        = cur;
    state_next      = state;
    avail_we        = 1'b0;
    fin             = 1'b0;
    res_c           = '0;

    stk.clr   = cfg_acc;
    stk.we    = 1'b0;
    stk.waddr = free_top[vqdm_pkg::IDX_W-1:0];
    stk.wdata = cur;
    stk.raddr = ft_dec[vqdm_pkg::IDX_W-1:0];

    lnk.we    = 1'b0;
    lnk.waddr = desc;
    lnk.flags = (wflag ? vqdm_pkg::DESC_F_WRITE : 2'd0) |
                (hnext ? vqdm_pkg::DESC_F_NEXT : 2'd0);
    lnk.next  = nidx;
    lnk.raddr = (state == S_IDLE) ? req.desc_id : cur;

    if (walk) begin
      // Push the current descriptor and follow its link
      stk.we        = 1'b1;
      free_top_next = ft_inc;
      freed_next    = freed + vqdm_pkg::SIZE_W'(1);
      if (state == S_EXEC) begin
        progress_next = progress + vqdm_pkg::CNT_W'(1);
      end
      if ((lnk_rdata.flags & vqdm_pkg::DESC_F_NEXT) == 2'd0) begin
        fin          = 1'b1;
        res_c.status = vqdm_pkg::STS_OK;
      end else if (lk_oor) begin
        fin          = 1'b1;
        res_c.status = vqdm_pkg::STS_RANGE;
      end else if (ft_inc >= eff_size) begin
        fin          = 1'b1;
        res_c.status = vqdm_pkg::STS_CHAIN;
      end else begin
        cur_next  = lnk_rdata.next;
        lnk.raddr = lnk_rdata.next;
      end
    end else if (state == S_EXEC) begin
      fin = 1'b1;
      case (act)
        vqdm_pkg::ACT_ALLOC: begin
          if (free_top == '0) begin
            res_c.status = vqdm_pkg::STS_NO_FREE;
          end else begin
            free_top_next   = ft_dec;
            res_c.index_out = stk_rdata;
          end
        end
        vqdm_pkg::ACT_LINK: begin
          if (desc_oor || nidx_oor) begin
            res_c.status = vqdm_pkg::STS_RANGE;
          end else begin
            lnk.we = 1'b1;
          end
        end
        vqdm_pkg::ACT_POST: begin
          if (desc_oor) begin
            res_c.status = vqdm_pkg::STS_RANGE;
          end else begin
            avail_we        = 1'b1;
            avail_head_next = avail_head + vqdm_pkg::CNT_W'(1);
            res_c.index_out = vqdm_pkg::IDX_W'(slot);
            // Track head mod size; the 16-bit head wrapping restarts at zero
            if (avail_head == '1 ||
                (vqdm_pkg::SIZE_W'(slot) + vqdm_pkg::SIZE_W'(1)) == eff_size) begin
              slot_next = '0;
            end else begin
              slot_next = slot + AW'(1);
            end
          end
        end
        vqdm_pkg::ACT_COMPLETE: begin
          // Range error, or nothing in use to return
          if (desc_oor) begin
            res_c.status = vqdm_pkg::STS_RANGE;
          end else begin
            res_c.status  = vqdm_pkg::STS_CHAIN;
            progress_next = progress + vqdm_pkg::CNT_W'(1);
          end
        end
        default: begin
          res_c.status = vqdm_pkg::STS_OK;
        end
      endcase
    end

    res_c.free_count    = free_top_next;
    res_c.avail_head    = avail_head_next;
    res_c.progress_head = progress_next;
    res_c.freed_count   = freed_next;

    // Advance the sequencer
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC, S_WALK: begin
        if (fin) begin
          state_next = out_free ? S_IDLE : S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eff_size   <= LIM_SZ;
      free_top   <= LIM_SZ;
      avail_head <= '0;
      slot       <= '0;
      progress   <= '0;
      freed      <= '0;
    end else if (cfg_acc) begin
      state      <= state_next;
      eff_size   <= cfg_eff;
      free_top   <= cfg_eff;
      avail_head <= '0;
      slot       <= '0;
      progress   <= '0;
      freed      <= '0;
    end else begin
      state      <= state_next;
      free_top   <= free_top_next;
      avail_head <= avail_head_next;
      slot       <= slot_next;
      progress   <= progress_next;
      freed      <= req_acc ? '0 : freed_next;
    end
  end

  // Hold the request and walk position
  always_ff @(posedge clk) begin
    if (req_acc) begin
      act   <= req.action;
      desc  <= req.desc_id;
      wflag <= req.write_flag;
      hnext <= req.has_next;
      nidx  <= req.next_index;
      cur   <= req.desc_id;
    end else begin
      cur   <= cur_next;
    end
    if (fin) begin
      res_hold <= res_c;
    end
  end

  // Avail ring
  always_ff @(posedge clk) begin
    if (avail_we) begin
      avail_ring[slot] <= desc[AW-1:0];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((fin || state == S_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      rsp_q <= res_c;
    end else if (state == S_DONE && out_free) begin
      rsp_q <= res_hold;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_q.status;
  assign rsp.index_out     = rsp_q.index_out;
  assign rsp.free_count    = rsp_q.free_count;
  assign rsp.avail_head    = rsp_q.avail_head;
  assign rsp.progress_head = rsp_q.progress_head;
  assign rsp.freed_count   = rsp_q.freed_count;

  vqdm_free_stack #(
    .DEPTH (LIM)
  ) u_free_stack (
    .clk   (clk),
    .rst   (rst),
    .req   (stk),
    .rdata (stk_rdata)
  );

  vqdm_link_mem #(
    .DEPTH (LIM)
  ) u_link_mem (
    .clk   (clk),
    .req   (lnk),
    .rdata (lnk_rdata)
  );

endmodule

/* test/virtqueue_descriptor_manager_tb.sv */
// Self-checking testbench for the split virtqueue descriptor manager: a shadow
// copy of the free stack, link table and ring counters predicts every response.
// Depends on vqdm_pkg, vqdm_if and virtqueue_descriptor_manager.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager_tb;
  import vqdm_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int CFG_SETTLE      = 4;
  localparam int DRAIN_CYCLES    = 300;
  localparam longint TIMEOUT_NS  = 64'd20_000_000;

  // One request transaction
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] desc_id;
    logic             write_flag;
    logic             has_next;
    logic [IDX_W-1:0] next_index;
  } vq_req_t;

  logic clk;
  logic rst;

  vqdm_cfg_if cfg_ch ();
  vqdm_req_if req_ch ();
  vqdm_rsp_if rsp_ch ();

  virtqueue_descriptor_manager DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow state of the block
  logic [IDX_W-1:0] shadow_stack [256];
  int               shadow_top;
  int               shadow_size;
  lnk_t             shadow_links [256];
  bit               link_written [256];
  logic [CNT_W-1:0] shadow_avail_head;
  logic [CNT_W-1:0] shadow_progress;

  rsp_t expected_rsp_q [$];
  int   mismatch_count;
  int   reqs_sent;
  bit   idle_off;
  bit   rsp_hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Refill the free stack and clear the ring counters, as a size write does
  function automatic void refill_shadow(logic [SIZE_W-1:0] qs);
    shadow_size = int'(qs);
    if (shadow_size < 1) shadow_size = 1;
    if (shadow_size > 256) shadow_size = 256;
    for (int i = 0; i < shadow_size; i++) shadow_stack[i] = i[IDX_W-1:0];
    shadow_top        = shadow_size;
    shadow_avail_head = '0;
    shadow_progress   = '0;
  endfunction

  // Walk a used chain the way complete does; false if it would read an unlinked entry
  function automatic bit walk_safe(logic [IDX_W-1:0] head);
    int   cap;
    int   cur;
    int   n;
    lnk_t lk;
    if (head >= shadow_size) return 1'b1;
    cap = shadow_size - shadow_top;
    if (cap == 0) return 1'b1;
    cur = int'(head);
    n   = 0;
    while (1) begin
      if (!link_written[cur]) return 1'b0;
      lk = shadow_links[cur];
      n++;
      if ((lk.flags & DESC_F_NEXT) == 2'd0) return 1'b1;
      if (lk.next >= shadow_size) return 1'b1;
      if (n >= cap) return 1'b1;
      cur = int'(lk.next);
    end
  endfunction

  // Apply one request to the shadow state and return the response it yields
  function automatic rsp_t predict_response(vq_req_t it);
    rsp_t r;
    int   cap;
    int   cur;
    int   freed;
    int   slot;
    lnk_t lk;
    r     = '0;
    freed = 0;
    r.status = STS_OK;
    case (it.action)
      ACT_ALLOC: begin
        if (shadow_top == 0) begin
          r.status = STS_NO_FREE;
        end else begin
          shadow_top--;
          r.index_out = shadow_stack[shadow_top];
        end
      end
      ACT_LINK: begin
        if (it.desc_id >= shadow_size || (it.has_next && it.next_index >= shadow_size)) begin
          r.status = STS_RANGE;
        end else begin
          lk.flags = (it.has_next ? DESC_F_NEXT : 2'd0) | (it.write_flag ? DESC_F_WRITE : 2'd0);
          lk.next  = it.next_index;
          shadow_links[it.desc_id] = lk;
          link_written[it.desc_id] = 1'b1;
        end
      end
      ACT_POST: begin
        if (it.desc_id >= shadow_size) begin
          r.status = STS_RANGE;
        end else begin
          slot = int'(shadow_avail_head) % shadow_size;
          shadow_avail_head = shadow_avail_head + 1'b1;
          r.index_out = slot[IDX_W-1:0];
        end
      end
      default: begin
        if (it.desc_id >= shadow_size) begin
          r.status = STS_RANGE;
        end else begin
          cap = shadow_size - shadow_top;
          cur = int'(it.desc_id);
          if (cap == 0) begin
            r.status = STS_CHAIN;
          end else begin
            // Push each descriptor of the chain back onto the free stack
            while (1) begin
              lk = shadow_links[cur];
              shadow_stack[shadow_top] = cur[IDX_W-1:0];
              shadow_top++;
              freed++;
              if ((lk.flags & DESC_F_NEXT) == 2'd0) break;
              if (lk.next >= shadow_size) begin
                r.status = STS_RANGE;
                break;
              end
              if (freed >= cap) begin
                r.status = STS_CHAIN;
                break;
              end
              cur = int'(lk.next);
            end
          end
          shadow_progress = shadow_progress + 1'b1;
        end
      end
    endcase
    if (r.status != STS_OK) r.index_out = '0;
    r.free_count    = shadow_top[SIZE_W-1:0];
    r.avail_head    = shadow_avail_head;
    r.progress_head = shadow_progress;
    r.freed_count   = freed[SIZE_W-1:0];
    return r;
  endfunction

  // Offer one request after a random gap; predict it once the transaction is taken
  task automatic send_req(input vq_req_t it, output rsp_t r);
    int gap;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.action     <= it.action;
    req_ch.desc_id    <= it.desc_id;
    req_ch.write_flag <= it.write_flag;
    req_ch.has_next   <= it.has_next;
    req_ch.next_index <= it.next_index;
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    r = predict_response(it);
    expected_rsp_q.insert(expected_rsp_q.size(), r);
    reqs_sent++;
  endtask

  task automatic send_op(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] d,
                         input logic w, input logic hn, input logic [IDX_W-1:0] nx,
                         output rsp_t r);
    vq_req_t it;
    it.action     = act;
    it.desc_id    = d;
    it.write_flag = w;
    it.has_next   = hn;
    it.next_index = nx;
    send_req(it, r);
  endtask

  // Drop valid and wait for every outstanding response
  task automatic wait_idle();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_queue_size(input logic [SIZE_W-1:0] qs);
    wait_idle();
    @(negedge clk);
    cfg_ch.queue_size <= qs;
    cfg_ch.valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    refill_shadow(qs);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // Random request; a complete that would walk into unlinked entries becomes a link
  task automatic send_noise();
    vq_req_t it;
    rsp_t    r;
    it.action     = ACT_W'($urandom_range(3));
    it.desc_id    = IDX_W'(($urandom_range(99) < 75) ? $urandom_range(shadow_size - 1)
                                                      : $urandom_range(255));
    it.write_flag = 1'($urandom_range(1));
    it.has_next   = 1'($urandom_range(1));
    it.next_index = IDX_W'(($urandom_range(99) < 80) ? $urandom_range(shadow_size - 1)
                                                      : $urandom_range(255));
    if (it.action == ACT_COMPLETE && !walk_safe(it.desc_id)) it.action = ACT_LINK;
    send_req(it, r);
  endtask

  // Driver-style traffic: allocate a chain, link it, post its head, complete heads later
  task automatic run_chain_traffic(input int n_items, input int max_len, input int noise_pct);
    int   pending [$];
    int   ids [$];
    int   stop_at;
    int   pick;
    int   len;
    int   k;
    int   h;
    rsp_t r;
    stop_at = reqs_sent + n_items;
    while (reqs_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < noise_pct) begin
        send_noise();
      end else if (pending.size() > 0 && (pick < noise_pct + 30 || shadow_top == 0)) begin
        k = $urandom_range(pending.size() - 1);
        h = pending[k];
        pending.delete(k);
        if (walk_safe(h[IDX_W-1:0]))
          send_op(ACT_COMPLETE, h[IDX_W-1:0], 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IDX_W'($urandom_range(255)), r);
      end else begin
        len = $urandom_range(max_len, 1);
        ids.delete();
        for (k = 0; k < len; k++) begin
          send_op(ACT_ALLOC, IDX_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), IDX_W'($urandom_range(255)), r);
          if (r.status != STS_OK) break;
          ids.insert(ids.size(), int'(r.index_out));
        end
        for (k = 0; k < ids.size(); k++) begin
          if (k + 1 < ids.size())
            send_op(ACT_LINK, IDX_W'(ids[k]), 1'($urandom_range(1)), 1'b1,
                    IDX_W'(ids[k + 1]), r);
          else
            send_op(ACT_LINK, IDX_W'(ids[k]), 1'($urandom_range(1)), 1'b0,
                    IDX_W'($urandom_range(255)), r);
        end
        if (ids.size() > 0) begin
          send_op(ACT_POST, IDX_W'(ids[0]), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IDX_W'($urandom_range(255)), r);
          pending.insert(pending.size(), ids[0]);
        end
      end
    end
  endtask

  // Reset size of 256: allocate from the top, round trip, cap of zero
  task automatic test_reset_defaults();
    rsp_t r;
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_LINK,     8'd255, 1'b1, 1'b0, 8'd255, r);
    send_op(ACT_POST,     8'd255, 1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_COMPLETE, 8'd255, 1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_LINK,     8'd0,   1'b0, 1'b1, 8'd1,   r);
    send_op(ACT_LINK,     8'd1,   1'b1, 1'b1, 8'd0,   r);
    send_op(ACT_LINK,     8'd2,   1'b0, 1'b1, 8'd200, r);
    send_op(ACT_LINK,     8'd3,   1'b1, 1'b0, 8'd0,   r);
    // Nothing in use: chain too long without a walk
    send_op(ACT_COMPLETE, 8'd3,   1'b1, 1'b1, 8'd255, r);
  endtask

  // Size 4: out-of-range fields, a broken link and a looping chain
  task automatic test_range_and_chain_faults();
    rsp_t r;
    write_queue_size(9'd4);
    send_op(ACT_LINK,     8'd4,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_LINK,     8'd1,   1'b0, 1'b1, 8'd4,   r);
    send_op(ACT_POST,     8'd4,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_COMPLETE, 8'd255, 1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    // Stored next of 200 is beyond the queue now
    send_op(ACT_COMPLETE, 8'd2,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_POST,     8'd0,   1'b0, 1'b0, 8'd0,   r);
    // 0 and 1 point at each other: walk stops at the in-use count
    send_op(ACT_COMPLETE, 8'd0,   1'b0, 1'b0, 8'd0,   r);
  endtask

  // Size register of zero clamps to one slot; 511 clamps to 256
  task automatic test_size_clamps();
    rsp_t r;
    write_queue_size(9'd0);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_COMPLETE, 8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_LINK,     8'd0,   1'b1, 1'b1, 8'd0,   r);
    write_queue_size(9'd511);
    send_op(ACT_ALLOC,    8'd0,   1'b0, 1'b0, 8'd0,   r);
    send_op(ACT_COMPLETE, 8'd255, 1'b0, 1'b0, 8'd0,   r);
  endtask

  task automatic test_small_queue_chains();
    write_queue_size(9'd8);
    run_chain_traffic(300, 4, 15);
  endtask

  task automatic test_tiny_queues();
    write_queue_size(9'd2);
    run_chain_traffic(150, 2, 20);
    write_queue_size(9'd1);
    run_chain_traffic(60, 1, 20);
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_response_backpressure();
    write_queue_size(9'd16);
    rsp_hold_req = 1'b1;
    run_chain_traffic(250, 6, 15);
  endtask

  task automatic test_back_to_back();
    write_queue_size(9'd37);
    idle_off = 1'b1;
    run_chain_traffic(200, 5, 15);
    wait_idle();
    idle_off = 1'b0;
  endtask

  task automatic test_full_queue_long_chains();
    write_queue_size(9'd256);
    run_chain_traffic(250, 48, 10);
    write_queue_size(9'd200);
    run_chain_traffic(150, 8, 15);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Compare each response transaction with the oldest prediction
  initial begin
    rsp_t exp_r;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_count++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("status",        32'(exp_r.status),        32'(rsp_ch.status));
          check_field("index_out",     32'(exp_r.index_out),     32'(rsp_ch.index_out));
          check_field("free_count",    32'(exp_r.free_count),    32'(rsp_ch.free_count));
          check_field("avail_head",    32'(exp_r.avail_head),    32'(rsp_ch.avail_head));
          check_field("progress_head", 32'(exp_r.progress_head), 32'(rsp_ch.progress_head));
          check_field("freed_count",   32'(exp_r.freed_count),   32'(rsp_ch.freed_count));
        end
      end
    end
  end

  // Response ready: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_off || $urandom_range(99) < 70) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  // Main sequence
  initial begin
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.queue_size = '0;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_ALLOC;
    req_ch.desc_id    = '0;
    req_ch.write_flag = 1'b0;
    req_ch.has_next   = 1'b0;
    req_ch.next_index = '0;
    mismatch_count    = 0;
    reqs_sent         = 0;
    idle_off          = 1'b0;
    rsp_hold_req      = 1'b0;
    for (int i = 0; i < 256; i++) link_written[i] = 1'b0;
    refill_shadow(9'd256);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_defaults();
    test_range_and_chain_faults();
    test_size_clamps();
    test_small_queue_chains();
    test_tiny_queues();
    test_response_backpressure();
    test_back_to_back();
    test_full_queue_long_chains();

    // Drain and let any stray response show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
